FILE: rtl/lfv_pkg.sv
// ----------------------------------------------------------------------------
// Link frame validator package
// Shared types and constants for the link frame validator.
// ----------------------------------------------------------------------------
`default_nettype none

package lfv_pkg;

  typedef enum logic [2:0] {
    StatusOk          = 3'd0,
    StatusTooShort    = 3'd1,
    StatusBadLength   = 3'd2,
    StatusLenMismatch = 3'd3,
    StatusCrcMismatch = 3'd4
  } status_e;

  localparam logic [7:0] CrcPolyReset   = 8'hD5;
  localparam logic [6:0] ByteCountMax   = 7'd127;
  localparam logic [7:0] MinFrameBytes  = 8'd4;
  localparam logic [7:0] MinLengthField = 8'd2;
  localparam logic [1:0] PayloadStart   = 2'd3;

  typedef struct packed {
    status_e    status;
    logic [7:0] frame_type;
    logic [5:0] payload_length;
    logic [1:0] payload_start;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/lfv_crc8.sv
// ----------------------------------------------------------------------------
// CRC-8 byte update
// Eight unrolled MSB-first shift steps of a CRC-8 with a programmable
// polynomial.
// ----------------------------------------------------------------------------
`default_nettype none

module lfv_crc8 (
  input  wire logic [7:0] crc_i,
  input  wire logic [7:0] data_i,
  input  wire logic [7:0] poly_i,
  output logic      [7:0] crc_o
);

  always_comb begin
    logic [7:0] c;
    c = crc_i ^ data_i;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly_i;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

`default_nettype wire

FILE: rtl/lfv_frame_check.sv
// ----------------------------------------------------------------------------
// Frame tracker and checker
// Holds the per-frame byte count, length and type bytes and running CRC,
// and forms the frame status when the final byte arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module lfv_frame_check #(
  parameter int unsigned MaxLengthField = 62
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       adv_i,
  input  wire logic [7:0] data_i,
  input  wire logic       last_i,
  input  wire logic [7:0] poly_i,
  output lfv_pkg::result_t result_o
);

  logic [6:0] byte_count_q, byte_count_d;
  logic [7:0] length_q, length_d;
  logic [7:0] type_q, type_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] crc_next;
  logic [7:0] total;
  logic [8:0] expected_total;
  lfv_pkg::status_e status;

  lfv_crc8 u_crc8 (
    .crc_i  (crc_q),
    .data_i (data_i),
    .poly_i (poly_i),
    .crc_o  (crc_next)
  );

  // The final byte carries the CRC itself, so it counts towards the length
  // but is not folded into the running CRC.
  assign total          = {1'b0, byte_count_q} + 8'd1;
  assign expected_total = {1'b0, length_q} + 9'd2;

  always_comb begin
    priority if (total < lfv_pkg::MinFrameBytes) begin
      status = lfv_pkg::StatusTooShort;
    end else if (length_q < lfv_pkg::MinLengthField ||
                 length_q > 8'(MaxLengthField)) begin
      status = lfv_pkg::StatusBadLength;
    end else if (expected_total != {1'b0, total}) begin
      status = lfv_pkg::StatusLenMismatch;
    end else if (crc_q != data_i) begin
      status = lfv_pkg::StatusCrcMismatch;
    end else begin
      status = lfv_pkg::StatusOk;
    end
  end

  always_comb begin
    result_o.status = status;
    if (status == lfv_pkg::StatusOk) begin
      result_o.frame_type     = type_q;
      result_o.payload_length = 6'(length_q - 8'd2);
      result_o.payload_start  = lfv_pkg::PayloadStart;
    end else begin
      result_o.frame_type     = '0;
      result_o.payload_length = '0;
      result_o.payload_start  = '0;
    end
  end

  always_comb begin
    byte_count_d = byte_count_q;
    length_d     = length_q;
    type_d       = type_q;
    crc_d        = crc_q;
    if (adv_i) begin
      if (last_i) begin
        byte_count_d = '0;
        length_d     = '0;
        type_d       = '0;
        crc_d        = '0;
      end else begin
        if (byte_count_q == 7'd1) begin
          length_d = data_i;
        end
        if (byte_count_q == 7'd2) begin
          type_d = data_i;
        end
        if (byte_count_q >= 7'd2) begin
          crc_d = crc_next;
        end
        if (byte_count_q != lfv_pkg::ByteCountMax) begin
          byte_count_d = byte_count_q + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      length_q     <= '0;
      type_q       <= '0;
      crc_q        <= '0;
    end else begin
      byte_count_q <= byte_count_d;
      length_q     <= length_d;
      type_q       <= type_d;
      crc_q        <= crc_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/link_frame_validator.sv
// A final byte's result is loaded from the input register into the output register.
// One byte per cycle unless stalled; the input register refills while the result waits.
// The CRC byte update is one unrolled eight-step pass between input and state registers.
// A stalled output holds back only final bytes; other bytes keep flowing.
// Reset clears frame state and valids, and loads the polynomial with 0xD5.
// ----------------------------------------------------------------------------
// Link frame validator
// Checks length and CRC-8 of byte-serial link frames and reports their type.
// ----------------------------------------------------------------------------
`default_nettype none

module link_frame_validator #(
  parameter int unsigned MaxLengthField = 62
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [2:0] status_o,
  output logic      [7:0] frame_type_o,
  output logic      [5:0] payload_length_o,
  output logic      [1:0] payload_start_o
);

  logic [7:0] crc_poly_q;
  logic       s1_valid_q;
  logic [7:0] s1_data_q;
  logic       s1_last_q;
  logic       s1_adv;
  logic       out_valid_q;
  lfv_pkg::result_t result;
  lfv_pkg::result_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_poly_q <= lfv_pkg::CrcPolyReset;
    end else if (cfg_we_i) begin
      crc_poly_q <= cfg_wdata_i;
    end
  end

  // Only a final byte needs room in the output register to move on.
  assign s1_adv     = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  lfv_frame_check #(
    .MaxLengthField (MaxLengthField)
  ) u_frame_check (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (s1_adv),
    .data_i   (s1_data_q),
    .last_i   (s1_last_q),
    .poly_i   (crc_poly_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      out_q <= result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign frame_type_o     = out_q.frame_type;
  assign payload_length_o = out_q.payload_length;
  assign payload_start_o  = out_q.payload_start;

endmodule

`default_nettype wire

FILE: tb/sv/link_frame_validator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Link frame validator testbench
// Feeds byte-serial frames (well-formed, corrupted, short, long and noise)
// through the valid/ready input, with random gaps on both sides. The CRC
// polynomial is changed between phases, at times in the middle of a frame. A
// predictor in the testbench works out the status of every frame, and a
// monitor compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------

module link_frame_validator_tb;

  localparam int unsigned MaxLenField  = 62;
  localparam int unsigned QuietLimit   = 200;
  localparam int unsigned PhaseCount   = 16;
  localparam int unsigned PhaseItems   = 100;
  localparam int unsigned SettleCycles = 6;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [7:0]  data;
    logic        last;
    int unsigned gap;
  } frame_item_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic       in_valid_i  = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [2:0] status_o;
  logic [7:0] frame_type_o;
  logic [5:0] payload_length_o;
  logic [1:0] payload_start_o;

  frame_item_t      pending_items[$];
  lfv_pkg::result_t expected_results[$];
  int unsigned queued_items = 0;
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_on      = 1'b1;
  bit          stall_on     = 1'b1;

  // Input driver state.
  bit          have_item = 1'b0;
  frame_item_t next_item;
  int unsigned gap_left  = 0;

  // Predictor copy of the frame state and the polynomial register.
  logic [6:0] rx_count = '0;
  logic [7:0] rx_len   = '0;
  logic [7:0] rx_type  = '0;
  logic [7:0] rx_crc   = '0;
  logic [7:0] rx_poly  = lfv_pkg::CrcPolyReset;

  link_frame_validator #(
    .MaxLengthField(MaxLenField)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .frame_type_o    (frame_type_o),
    .payload_length_o(payload_length_o),
    .payload_start_o (payload_start_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b, logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

  // CRC over the type byte and the payload, i.e. from index 2 to the end.
  function automatic logic [7:0] frame_crc(byte_q_t f, logic [7:0] poly);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 2; i < f.size(); i++) begin
      c = crc8_step(c, f[i], poly);
    end
    return c;
  endfunction

  // Address, length field, type and payload; the CRC byte is left to the caller.
  function automatic byte_q_t build_frame(int unsigned plen);
    byte_q_t f;
    f.push_back(8'($urandom_range(0, 255)));
    f.push_back(8'(plen + 2));
    f.push_back(8'($urandom_range(0, 255)));
    repeat (plen) f.push_back(8'($urandom_range(0, 255)));
    return f;
  endfunction

  function automatic void absorb_frame_byte(logic [7:0] b, logic last);
    lfv_pkg::result_t r;
    lfv_pkg::status_e st;
    int               total;
    if (!last) begin
      if (rx_count == 7'd1) rx_len = b;
      if (rx_count == 7'd2) rx_type = b;
      if (rx_count >= 7'd2) rx_crc = crc8_step(rx_crc, b, rx_poly);
      if (rx_count != lfv_pkg::ByteCountMax) rx_count = rx_count + 7'd1;
    end else begin
      total = int'(rx_count) + 1;
      if (total < 4) st = lfv_pkg::StatusTooShort;
      else if (rx_len < 8'd2 || int'(rx_len) > MaxLenField) st = lfv_pkg::StatusBadLength;
      else if (int'(rx_len) + 2 != total) st = lfv_pkg::StatusLenMismatch;
      else if (rx_crc != b) st = lfv_pkg::StatusCrcMismatch;
      else st = lfv_pkg::StatusOk;
      r = '0;
      r.status = st;
      if (st == lfv_pkg::StatusOk) begin
        r.frame_type     = rx_type;
        r.payload_length = 6'(rx_len - 8'd2);
        r.payload_start  = lfv_pkg::PayloadStart;
      end
      expected_results.push_back(r);
      rx_count = '0;
      rx_len   = '0;
      rx_type  = '0;
      rx_crc   = '0;
    end
  endfunction

  task automatic queue_bytes(byte_q_t f, bit mark_last);
    frame_item_t it;
    for (int i = 0; i < f.size(); i++) begin
      it.data = f[i];
      it.last = mark_last && (i == f.size() - 1);
      it.gap  = idle_on ? $urandom_range(0, 8) : 0;
      pending_items.push_back(it);
      queued_items++;
    end
  endtask

  task automatic queue_random_frame();
    byte_q_t     f;
    int unsigned kind;
    int unsigned plen;
    kind = $urandom_range(0, 99);
    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
    f = build_frame(plen);
    if (kind < 60) begin
      f.push_back(frame_crc(f, rx_poly));
    end else if (kind < 70) begin
      f.push_back(frame_crc(f, rx_poly) ^ 8'($urandom_range(1, 255)));
    end else if (kind < 78) begin
      case ($urandom_range(0, 4))
        0: f[1] = 8'd0;
        1: f[1] = 8'd1;
        2: f[1] = 8'(MaxLenField + 1);
        3: f[1] = 8'hFF;
        default: f[1] = f[1] + 8'($urandom_range(1, 255));
      endcase
      f.push_back(frame_crc(f, rx_poly));
    end else if (kind < 85) begin
      f.delete();
      repeat ($urandom_range(1, 3)) f.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 90) begin
      // Sound CRC, but the last flag comes one byte late or one byte early.
      f.push_back(frame_crc(f, rx_poly));
      if ($urandom_range(0, 1) != 0) f.push_back(8'($urandom_range(0, 255)));
      else void'(f.pop_back());
    end else if (kind < 99) begin
      f.delete();
      repeat ($urandom_range(1, 20)) f.push_back(8'($urandom_range(0, 255)));
    end else begin
      // Long frame: the byte count saturates, so the length can never match.
      f = build_frame(0);
      f[1] = 8'($urandom_range(2, MaxLenField));
      repeat ($urandom_range(125, 132)) f.push_back(8'($urandom_range(0, 255)));
    end
    queue_bytes(f, 1'b1);
  endtask

  task automatic wait_for_drain();
    do begin
      @(negedge clk_i);
    end while (pending_items.size() != 0 || have_item || in_valid_i ||
               expected_results.size() != 0);
  endtask

  // Only called once the block is idle; the pause lets a trailing byte settle.
  task automatic write_polynomial(logic [7:0] poly);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_wdata_i <= poly;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    rx_poly = poly;
    @(negedge clk_i);
  endtask

  // Input driver.
  always @(posedge clk_i or negedge rst_ni) begin
    logic next_valid;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      data_byte_i <= 8'h00;
      last_byte_i <= 1'b0;
    end else begin
      next_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        absorb_frame_byte(data_byte_i, last_byte_i);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (!have_item && pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          gap_left  = next_item.gap;
          have_item = 1'b1;
        end
        if (have_item) begin
          if (gap_left == 0) begin
            data_byte_i <= next_item.data;
            last_byte_i <= next_item.last;
            next_valid  = 1'b1;
            have_item   = 1'b0;
          end else begin
            gap_left--;
          end
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // Result monitor.
  int unsigned ready_wait = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    lfv_pkg::result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_wait = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction, status %0d", $time, status_o);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, status_o);
            fail_count++;
          end
          if (frame_type_o !== want.frame_type) begin
            $display("%0t: frame_type expected %0h, got %0h", $time, want.frame_type,
                     frame_type_o);
            fail_count++;
          end
          if (payload_length_o !== want.payload_length) begin
            $display("%0t: payload_length expected %0d, got %0d", $time,
                     want.payload_length, payload_length_o);
            fail_count++;
          end
          if (payload_start_o !== want.payload_start) begin
            $display("%0t: payload_start expected %0d, got %0d", $time, want.payload_start,
                     payload_start_o);
            fail_count++;
          end
        end
        ready_wait = stall_on ? $urandom_range(0, 8) : 0;
      end else if (ready_wait != 0) begin
        ready_wait--;
      end
      out_ready_i <= (ready_wait == 0);
    end
  end

  // Watchdog on cycles in which neither channel moves a transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
        $display("link_frame_validator test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    byte_q_t     f;
    byte_q_t     tail;
    logic [7:0]  split_crc;
    logic [7:0]  poly;
    int unsigned phase_start;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed frames under the reset polynomial.
    f = '{8'hC8, 8'h02, 8'h00};
    f.push_back(frame_crc(f, rx_poly));
    queue_bytes(f, 1'b1);
    f = '{8'hFF, 8'h03, 8'hFF, 8'hFF};
    f.push_back(frame_crc(f, rx_poly));
    queue_bytes(f, 1'b1);
    f = '{8'h00};
    queue_bytes(f, 1'b1);
    f = '{8'hC8, 8'h02, 8'h00};
    queue_bytes(f, 1'b1);
    f = '{8'hC8, 8'(MaxLenField + 1), 8'h10};
    f.push_back(frame_crc(f, rx_poly));
    queue_bytes(f, 1'b1);
    f = '{8'hC8, 8'h03, 8'h10};
    f.push_back(frame_crc(f, rx_poly));
    queue_bytes(f, 1'b1);
    f = '{8'hC8, 8'h02, 8'h10};
    f.push_back(frame_crc(f, rx_poly) ^ 8'h01);
    queue_bytes(f, 1'b1);
    wait_for_drain();

    // Polynomial change in the middle of a frame: each byte uses the value
    // current when it is taken in.
    f = build_frame(3);
    tail = '{f[4], f[5]};
    f = f[0:3];
    split_crc = crc8_step(8'h00, f[2], rx_poly);
    split_crc = crc8_step(split_crc, f[3], rx_poly);
    queue_bytes(f, 1'b0);
    wait_for_drain();
    write_polynomial(8'h07);
    split_crc = crc8_step(split_crc, tail[0], rx_poly);
    split_crc = crc8_step(split_crc, tail[1], rx_poly);
    tail.push_back(split_crc);
    queue_bytes(tail, 1'b1);
    wait_for_drain();

    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: poly = 8'h00;
        1: poly = 8'hFF;
        2: poly = lfv_pkg::CrcPolyReset;
        default: poly = 8'($urandom_range(0, 255));
      endcase
      write_polynomial(poly);
      idle_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      phase_start = queued_items;
      if (phase == 0) begin
        f = build_frame(60);
        f.push_back(frame_crc(f, rx_poly));
        queue_bytes(f, 1'b1);
      end
      while (queued_items - phase_start < PhaseItems) queue_random_frame();
      // Sometimes leave a frame open so that the next setting lands mid-frame.
      if (phase < PhaseCount - 1 && $urandom_range(0, 2) == 0) begin
        f = build_frame($urandom_range(0, 6));
        queue_bytes(f, 1'b0);
      end
      wait_for_drain();
    end

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("link_frame_validator test passed");
    end else begin
      $display("link_frame_validator test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lfv_pkg.sv
rtl/lfv_crc8.sv
rtl/lfv_frame_check.sv
rtl/link_frame_validator.sv
tb/sv/link_frame_validator_tb.sv
